[rtl/slm_pkg.sv]
package slm_pkg;

  localparam int DEF_LIST_DEPTH  = 16;
  localparam int DEF_VALUE_WIDTH = 32;
  localparam int DATA_W          = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic MODE_LIST_A = 1'b0;
  localparam logic MODE_LIST_B = 1'b1;

  typedef struct packed {
    logic to_b;
    logic last;
  } cmd_ctl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_PICK
  } back_st_t;

endpackage

[rtl/sorted_list_merge.sv]
// Load: one item per cycle while the queue has room; each item is then popped from
//   the queue and written to its list store. Merge: after the last item, each result
//   takes a list memory read (ST_READ), then a compare and output load (ST_PICK).
// Input stays open during a merge until the 2-entry queue fills.
// Reset (rst_n low, synchronous): counts, drop flag, queue and output valid clear;
//   list memories keep their contents; an unwritten entry is never picked as a result.
module sorted_list_merge #(
  parameter int LIST_DEPTH  = slm_pkg::DEF_LIST_DEPTH,
  parameter int VALUE_WIDTH = slm_pkg::DEF_VALUE_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [slm_pkg::DATA_W-1:0] in_tdata,   // value
  input  logic                       in_tuser,   // mode
  input  logic                       in_tlast,   // last
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [slm_pkg::DATA_W-1:0] out_tdata,  // merged_value
  output logic                       out_tuser,  // overflow
  output logic                       out_tlast   // final_res
);

  logic                          q_valid;
  logic                          q_pop;
  slm_pkg::cmd_ctl_t             q_ctl;
  logic signed [VALUE_WIDTH-1:0] q_value;

  slm_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_ctl     (q_ctl),
    .q_value   (q_value)
  );

  slm_back #(
    .LIST_DEPTH  (LIST_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_ctl      (q_ctl),
    .q_value    (q_value),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[rtl/slm_front.sv]
module slm_front #(
  parameter int VALUE_WIDTH = slm_pkg::DEF_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [slm_pkg::DATA_W-1:0]    in_tdata,  // value
  input  logic                          in_tuser,  // mode
  input  logic                          in_tlast,  // last
  output logic                          q_valid,
  input  logic                          q_pop,
  output slm_pkg::cmd_ctl_t             q_ctl,
  output logic signed [VALUE_WIDTH-1:0] q_value
);

  slm_pkg::cmd_ctl_t                q_ctl_r [slm_pkg::QUEUE_DEPTH];
  logic signed [VALUE_WIDTH-1:0]    q_val_r [slm_pkg::QUEUE_DEPTH];
  logic [slm_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [slm_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [slm_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;
  logic                             push;
  logic                             pop;
  slm_pkg::cmd_ctl_t                in_ctl;
  logic signed [VALUE_WIDTH-1:0]    in_val;

  // classify: pick the list, fit the value to the stored width
  always_comb begin
    in_ctl.to_b = (in_tuser == slm_pkg::MODE_LIST_B);
    in_ctl.last = in_tlast;
    in_val      = VALUE_WIDTH'($signed(in_tdata));
  end

  assign in_tready = (cnt_r != slm_pkg::QCNT_W'(slm_pkg::QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_ctl     = q_ctl_r[rd_ptr_r];
  assign q_value   = q_val_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_ctl_r[wr_ptr_r] <= in_ctl;
      q_val_r[wr_ptr_r] <= in_val;
    end
  end

endmodule

[rtl/slm_back.sv]
module slm_back #(
  parameter int LIST_DEPTH  = slm_pkg::DEF_LIST_DEPTH,
  parameter int VALUE_WIDTH = slm_pkg::DEF_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  slm_pkg::cmd_ctl_t             q_ctl,
  input  logic signed [VALUE_WIDTH-1:0] q_value,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [slm_pkg::DATA_W-1:0]    out_tdata,  // merged_value
  output logic                          out_tuser,  // overflow
  output logic                          out_tlast   // final_res
);

  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  logic signed [VALUE_WIDTH-1:0] mem_a [LIST_DEPTH];
  logic signed [VALUE_WIDTH-1:0] mem_b [LIST_DEPTH];

  slm_pkg::back_st_t             state_r, state_nxt;
  logic [CNT_W-1:0]              cnt_a_r, cnt_a_nxt;
  logic [CNT_W-1:0]              cnt_b_r, cnt_b_nxt;
  logic [CNT_W-1:0]              ia_r, ia_nxt;
  logic [CNT_W-1:0]              ib_r, ib_nxt;
  logic                          drop_r, drop_nxt;
  logic signed [VALUE_WIDTH-1:0] rd_a_r;
  logic signed [VALUE_WIDTH-1:0] rd_b_r;
  logic                          out_valid_r, out_valid_nxt;
  logic [slm_pkg::DATA_W-1:0]    out_value_r;
  logic                          out_final_r;
  logic                          out_ovf_r;

  logic                          wr_a;
  logic                          wr_b;
  logic                          rd_en;
  logic                          load_out;
  logic                          out_free;
  logic                          a_left;
  logic                          b_left;
  logic                          take_a;
  logic                          is_final;
  logic signed [VALUE_WIDTH-1:0] sel_val;

  assign out_free = !out_valid_r || out_tready;
  assign a_left   = (ia_r < cnt_a_r);
  assign b_left   = (ib_r < cnt_b_r);
  assign take_a   = a_left && (!b_left || (rd_a_r < rd_b_r));
  assign sel_val  = take_a ? rd_a_r : rd_b_r;
  assign is_final = (SUM_W'(ia_r) + SUM_W'(ib_r) + SUM_W'(1))
                    == (SUM_W'(cnt_a_r) + SUM_W'(cnt_b_r));

  always_comb begin
    state_nxt     = state_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    ia_nxt        = ia_r;
    ib_nxt        = ib_r;
    drop_nxt      = drop_r;
    q_pop         = 1'b0;
    wr_a          = 1'b0;
    wr_b          = 1'b0;
    rd_en         = 1'b0;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      slm_pkg::ST_LOAD: begin
        q_pop = q_valid;
        if (q_valid) begin
          if (!q_ctl.to_b) begin
            if (cnt_a_r < CNT_W'(LIST_DEPTH)) begin
              wr_a      = 1'b1;
              cnt_a_nxt = cnt_a_r + 1'b1;
            end else begin
              drop_nxt = 1'b1;
            end
          end else begin
            if (cnt_b_r < CNT_W'(LIST_DEPTH)) begin
              wr_b      = 1'b1;
              cnt_b_nxt = cnt_b_r + 1'b1;
            end else begin
              drop_nxt = 1'b1;
            end
          end
          if (q_ctl.last) begin
            ia_nxt    = '0;
            ib_nxt    = '0;
            state_nxt = slm_pkg::ST_READ;
          end
        end
      end
      slm_pkg::ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = slm_pkg::ST_PICK;
      end
      slm_pkg::ST_PICK: begin
        if (out_free) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          if (take_a) begin
            ia_nxt = ia_r + 1'b1;
          end else begin
            ib_nxt = ib_r + 1'b1;
          end
          if (is_final) begin
            cnt_a_nxt = '0;
            cnt_b_nxt = '0;
            drop_nxt  = 1'b0;
            state_nxt = slm_pkg::ST_LOAD;
          end else begin
            state_nxt = slm_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_nxt = slm_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slm_pkg::ST_LOAD;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ia_r        <= '0;
      ib_r        <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      ia_r        <= ia_nxt;
      ib_r        <= ib_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[cnt_a_r[IDX_W-1:0]] <= q_value;
    end
    if (wr_b) begin
      mem_b[cnt_b_r[IDX_W-1:0]] <= q_value;
    end
    if (rd_en) begin
      rd_a_r <= mem_a[ia_r[IDX_W-1:0]];
      rd_b_r <= mem_b[ib_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_value_r <= slm_pkg::DATA_W'(sel_val);
      out_final_r <= is_final;
      out_ovf_r   <= drop_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tlast  = out_final_r;
  assign out_tuser  = out_ovf_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= CNT_W'(LIST_DEPTH)) && (cnt_b_r <= CNT_W'(LIST_DEPTH)))
    else $error("list count beyond depth");

  a_pick_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == slm_pkg::ST_PICK) |-> (a_left || b_left))
    else $error("merge step with both lists exhausted");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != slm_pkg::ST_LOAD) |-> ((ia_r <= cnt_a_r) && (ib_r <= cnt_b_r)))
    else $error("merge index past list count");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == slm_pkg::ST_PICK && out_free && is_final)
    |=> (cnt_a_r == '0 && cnt_b_r == '0 && !drop_r && out_tvalid && out_tlast))
    else $error("final result without clear");

  a_no_pop_in_merge: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != slm_pkg::ST_LOAD) |-> !q_pop)
    else $error("queue popped during merge");

endmodule

[dv/slm_checker.sv]
module slm_checker #(
  parameter int DEPTH = slm_pkg::DEF_LIST_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [slm_pkg::DATA_W-1:0] in_tdata,
  input  logic                       in_tuser,
  input  logic                       in_tlast,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [slm_pkg::DATA_W-1:0] out_tdata,
  input  logic                       out_tuser,
  input  logic                       out_tlast,
  output int                         errors,
  output int                         pending,
  output int                         results_seen
);

  typedef struct {
    logic [slm_pkg::DATA_W-1:0] value;
    logic                       is_final;
    logic                       ovf;
  } merged_t;

  logic signed [slm_pkg::DATA_W-1:0] list_a [DEPTH];
  logic signed [slm_pkg::DATA_W-1:0] list_b [DEPTH];
  int                                count_a;
  int                                count_b;
  logic                              dropped;
  merged_t                           merged_q[$];

  task automatic merge_lists();
    int      ia;
    int      ib;
    int      total;
    merged_t m;
    ia = 0;
    ib = 0;
    total = count_a + count_b;
    for (int k = 0; k < total; k++) begin
      if (ia < count_a && (ib >= count_b || list_a[ia] < list_b[ib])) begin
        m.value = list_a[ia];
        ia++;
      end else begin
        m.value = list_b[ib];
        ib++;
      end
      m.is_final = (k == total - 1);
      m.ovf = dropped;
      merged_q.push_back(m);
    end
    count_a = 0;
    count_b = 0;
    dropped = 1'b0;
  endtask

  task automatic flag(input string what);
    errors++;
    if (errors <= 10) begin
      $display("[%0t] %s; got value %0d final %0b ovf %0b", $time, what,
               $signed(out_tdata), out_tlast, out_tuser);
    end
  endtask

  always @(posedge clk) begin
    merged_t want;
    if (!rst_n) begin
      count_a = 0;
      count_b = 0;
      dropped = 1'b0;
      merged_q.delete();
      errors = 0;
      results_seen = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (in_tuser == slm_pkg::MODE_LIST_A) begin
          if (count_a < DEPTH) begin
            list_a[count_a] = in_tdata;
            count_a++;
          end else begin
            dropped = 1'b1;
          end
        end else begin
          if (count_b < DEPTH) begin
            list_b[count_b] = in_tdata;
            count_b++;
          end else begin
            dropped = 1'b1;
          end
        end
        if (in_tlast) begin
          merge_lists();
        end
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (merged_q.size() == 0) begin
          flag("unexpected item");
        end else begin
          want = merged_q.pop_front();
          if (out_tdata !== want.value || out_tlast !== want.is_final ||
              out_tuser !== want.ovf) begin
            flag($sformatf("mismatch, expected value %0d final %0b ovf %0b",
                           $signed(want.value), want.is_final, want.ovf));
          end
        end
      end
    end
    pending = merged_q.size();
  end

endmodule

[dv/tb.sv]
module tb;

  localparam int DEPTH = slm_pkg::DEF_LIST_DEPTH;
  localparam int ITEMS = 370;
  localparam int LIMIT = 200000;

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       in_tvalid  = 1'b0;
  logic                       in_tready;
  logic [slm_pkg::DATA_W-1:0] in_tdata   = '0;
  logic                       in_tuser   = slm_pkg::MODE_LIST_A;
  logic                       in_tlast   = 1'b0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [slm_pkg::DATA_W-1:0] out_tdata;
  logic                       out_tuser;
  logic                       out_tlast;

  int errors;
  int pending;
  int results_seen;
  int cycles       = 0;
  int items_sent   = 0;
  int frames       = 0;
  int ovf_frames   = 0;
  int burst_left   = 0;
  int ready_tick   = 0;
  int ready_style  = 0;

  int list_a_vals[$];
  int list_b_vals[$];

  sorted_list_merge dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // value
    .in_tuser   (in_tuser),   // mode
    .in_tlast   (in_tlast),   // last
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // merged_value
    .out_tuser  (out_tuser),  // overflow
    .out_tlast  (out_tlast)   // final_res
  );

  slm_checker #(.DEPTH(DEPTH)) u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  // hold off the result side: always ready, coin flip, periodic, or mostly stalled
  always @(posedge clk) begin
    ready_tick <= ready_tick + 1;
    if (ready_tick % 64 == 0) begin
      ready_style <= $urandom_range(0, 3);
    end
    case (ready_style)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 1);
      2: out_tready <= (ready_tick % 5 != 0);
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_item(input logic mode, input logic [slm_pkg::DATA_W-1:0] val,
                           input logic last);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= val;
    in_tuser  <= mode;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic fill_list(input bit to_b, input int n, input int step_max,
                           input bit sorted);
    longint cur;
    int     v;
    cur = (step_max > 1000) ? -64'sd2147483648 + longint'($urandom_range(0, 32'h3fff_ffff))
                            : longint'(int'($urandom));
    for (int i = 0; i < n; i++) begin
      v = sorted ? int'(cur) : int'($urandom);
      if (to_b) list_b_vals.push_back(v);
      else list_a_vals.push_back(v);
      cur += $urandom_range(0, step_max);
      if (cur > 64'sd2147483647) cur = 64'sd2147483647;
    end
  endtask

  // interleave both lists at random; the final item carries last
  task automatic play_frame();
    logic mode;
    int   v;
    frames++;
    if (list_a_vals.size() > DEPTH || list_b_vals.size() > DEPTH) ovf_frames++;
    while (list_a_vals.size() + list_b_vals.size() > 0) begin
      if (list_b_vals.size() == 0 ||
          (list_a_vals.size() != 0 && $urandom_range(0, 1) == 0)) begin
        mode = slm_pkg::MODE_LIST_A;
        v = list_a_vals.pop_front();
      end else begin
        mode = slm_pkg::MODE_LIST_B;
        v = list_b_vals.pop_front();
      end
      send_item(mode, v, list_a_vals.size() + list_b_vals.size() == 0);
    end
  endtask

  initial begin
    int kind;
    int step_max;
    int na;
    int nb;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    list_a_vals = '{32'sh8000_0000, 32'sh7fff_ffff};
    list_b_vals = '{32'sh8000_0000, 32'sh7fff_ffff};
    play_frame();
    list_a_vals = '{-1, 3};
    list_b_vals = '{3, 3};
    play_frame();
    list_b_vals = '{0};
    play_frame();
    for (int i = 0; i <= DEPTH; i++) list_a_vals.push_back(i * 7 - 50);
    play_frame();

    while (items_sent < ITEMS) begin
      kind = $urandom_range(0, 9);
      case ($urandom_range(0, 2))
        0: step_max = 2;
        1: step_max = 1000;
        default: step_max = 32'h0800_0000;
      endcase
      if (kind < 7) begin
        na = $urandom_range(0, ($urandom_range(0, 2) == 0) ? DEPTH : 5);
        nb = $urandom_range(0, ($urandom_range(0, 2) == 0) ? DEPTH : 5);
        if (na + nb == 0) na = 1;
      end else begin
        na = (kind == 7) ? $urandom_range(DEPTH + 1, DEPTH + 3) : $urandom_range(0, 10);
        nb = $urandom_range(1, (kind == 7) ? DEPTH : 10);
        if (kind == 7 && $urandom_range(0, 1) == 1) begin
          kind = na;
          na = nb;
          nb = kind;
          kind = 7;
        end
      end
      fill_list(1'b0, na, step_max, kind < 8);
      fill_list(1'b1, nb, step_max, kind < 8);
      play_frame();
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d items in %0d frames (%0d with a full list), checked %0d results.",
             items_sent, frames, ovf_frames, results_seen);
    $display("Mismatches: %0d, results still outstanding: %0d.", errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    wait (cycles >= LIMIT);
    $display("Timeout after %0d cycles.", cycles);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
